[rtl/core/fsub_pkg.sv]
// Shared types, constants and helpers for the first substring match block.
package fsub_pkg;

   // Default sizes
   localparam int MAX_PATTERN_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;

   // Fixed field widths
   localparam int BYTE_BITS     = 8;
   localparam int CSR_LEN_BITS  = 5;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 2;
   localparam int START_BITS    = 16;
   localparam logic [START_BITS-1:0] START_MAX = '1;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_PATTERN_LOW    = 2'd1,
      REG_PATTERN_HIGH   = 2'd2
   } csr_index_type;

   // Control handed to every window cell
   typedef struct packed {
      logic shift;   // a beat is accepted, window moves by one
      logic active;  // cell lies inside the current pattern length
   } cell_ctrl_type;

   // Pattern byte k from the two pattern words; bytes past 15 read as zero
   function automatic logic [BYTE_BITS-1:0] pattern_at(
      input logic [CSR_DATA_BITS-1:0] low,
      input logic [CSR_DATA_BITS-1:0] high,
      input int                       k
   );
      logic [BYTE_BITS-1:0] b;
      b = '0;
      if (k >= 0 && k < 8) begin
         b = low[8*k +: 8];
      end else if (k >= 8 && k < 16) begin
         b = high[8*(k-8) +: 8];
      end
      return b;
   endfunction

endpackage

[rtl/core/fsub_cell.sv]
// One window cell: holds one text byte, passes it on, and compares the byte it takes in.
module fsub_cell (
   input  logic                           clock,
   input  fsub_pkg::cell_ctrl_type        ctrl,
   input  logic [fsub_pkg::BYTE_BITS-1:0] byte_in,
   input  logic [fsub_pkg::BYTE_BITS-1:0] pattern_byte,
   output logic [fsub_pkg::BYTE_BITS-1:0] byte_out,
   output logic                           match
);

   logic [fsub_pkg::BYTE_BITS-1:0] byte_ff;
   logic [fsub_pkg::BYTE_BITS-1:0] byte_in_val;

   // Value this cell holds after the beat
   assign byte_in_val = ctrl.shift ? byte_in : byte_ff;

   // Cells past the pattern length never block a hit
   assign match = !ctrl.active || (byte_in == pattern_byte);

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_val;
   end

   assign byte_out = byte_ff;

endmodule

[rtl/core/first_substring_match.sv]
// Top level of the first substring match block: window chain, position tracking, result register.
//
//   channel | dir | handshake        | payload
//   req     | in  | tvalid / tready  | tdata[7:0] text_byte, tlast last_byte
//   rsp     | out | tvalid / tready  | tdata[15:0] match_start, tuser found
//   csr     | in  | we (no wait)     | index, wdata (pattern registers)
//
// One text byte is taken per cycle while req_tready is high; the compare over all window
// cells and the position update finish in the cycle the byte is accepted.
// A result is loaded into the output register on the beat marked last and is held there
// until rsp_tready takes it; req_tready stays high while that register is empty or draining.
// Synchronous reset clears the counters, the match flag, the output valid and sets
// the pattern registers to length 1 and all-zero bytes. No clearing pass is needed.
module first_substring_match #(
   parameter int MAX_PATTERN   = fsub_pkg::MAX_PATTERN_DEF,
   parameter int POSITION_BITS = fsub_pkg::POSITION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input text stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] text_byte
   input  logic                               req_tlast,   // last_byte
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [15:0] match_start
   output logic                               rsp_tuser,   // [0] found
   // configuration writes
   input  logic                               csr_we,
   input  logic [fsub_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fsub_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Configuration registers
   logic [fsub_pkg::CSR_LEN_BITS-1:0]  pattern_length_ff;
   logic [fsub_pkg::CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [fsub_pkg::CSR_DATA_BITS-1:0] pattern_high_ff;

   // Text state
   logic [POSITION_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                     have_match_ff, have_match_in;
   logic [POSITION_BITS-1:0] first_start_ff, first_start_in;

   // Output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [fsub_pkg::START_BITS-1:0]  rsp_start_ff, rsp_start_in;

   logic                     accept;
   logic [LEN_W-1:0]         used_len;
   logic [POSITION_BITS-1:0] seen_next;
   logic [POSITION_BITS-1:0] start_cand;
   logic                     hit;
   logic                     found_next;
   logic [POSITION_BITS-1:0] start_next;
   logic [MAX_PATTERN-1:0]   cell_match;
   logic [fsub_pkg::BYTE_BITS-1:0] chain [MAX_PATTERN+1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= fsub_pkg::CSR_LEN_BITS'(1);
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fsub_pkg::REG_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_wdata[fsub_pkg::CSR_LEN_BITS-1:0];
            end
            fsub_pkg::REG_PATTERN_LOW: begin
               pattern_low_ff <= csr_wdata;
            end
            fsub_pkg::REG_PATTERN_HIGH: begin
               pattern_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Effective length: zero acts as one, clamp at the window depth
   always_comb begin
      if (pattern_length_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (int'(pattern_length_ff) > MAX_PATTERN) begin
         used_len = LEN_W'(MAX_PATTERN);
      end else begin
         used_len = LEN_W'(pattern_length_ff);
      end
   end

   // Window chain: cell 0 takes the newest byte
   assign chain[0] = req_tdata[7:0];

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      fsub_pkg::cell_ctrl_type        ctrl;
      logic [fsub_pkg::BYTE_BITS-1:0] pat;

      // cell i lines up with pattern byte (length - 1 - i)
      always_comb begin
         ctrl.shift  = accept;
         ctrl.active = (i < int'(used_len));
         pat         = fsub_pkg::pattern_at(pattern_low_ff, pattern_high_ff,
                                            int'(used_len) - 1 - i);
      end

      fsub_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .byte_in      (chain[i]),
         .pattern_byte (pat),
         .byte_out     (chain[i+1]),
         .match        (cell_match[i])
      );
   end

   // Position tracking and first-hit capture
   always_comb begin
      seen_next  = (bytes_seen_ff == POS_MAX) ? bytes_seen_ff : bytes_seen_ff + 1'b1;
      start_cand = seen_next - POSITION_BITS'(used_len);
      hit        = (&cell_match) && (seen_next >= POSITION_BITS'(used_len));
      found_next = have_match_ff || hit;
      start_next = have_match_ff ? first_start_ff : (hit ? start_cand : '0);

      bytes_seen_in  = bytes_seen_ff;
      have_match_in  = have_match_ff;
      first_start_in = first_start_ff;
      if (accept) begin
         if (req_tlast) begin
            bytes_seen_in  = '0;
            have_match_in  = 1'b0;
            first_start_in = '0;
         end else begin
            bytes_seen_in  = seen_next;
            have_match_in  = found_next;
            first_start_in = start_next;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_next;
         if (!found_next) begin
            rsp_start_in = '0;
         end else if (32'(start_next) > 32'(fsub_pkg::START_MAX)) begin
            rsp_start_in = fsub_pkg::START_MAX;
         end else begin
            rsp_start_in = fsub_pkg::START_BITS'(start_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff  <= '0;
         have_match_ff  <= 1'b0;
         first_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bytes_seen_ff  <= bytes_seen_in;
         have_match_ff  <= have_match_in;
         first_start_ff <= first_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_start_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

[tb/first_substring_match_tb.sv]
// Self-checking testbench for the first substring match block: stream stimulus and scoreboard.
`timescale 1ns / 100ps

// One search result as it leaves the block
typedef struct packed {
   logic        found;
   logic [15:0] start;
} match_result_type;

// Scoreboard: tracks the search state per text and queues the expected result beats
class match_scoreboard;
   logic [4:0]       len_reg;
   logic [127:0]     pattern;      // pattern byte k sits at [8k +: 8]
   logic [7:0]       window [16];  // index 0 is the newest byte
   logic [15:0]      seen_count;
   bit               matched;
   logic [15:0]      match_pos;
   match_result_type expected_q [$];
   int               errors;
   int               texts;
   int               found_count;

   function new();
      len_reg     = 5'd1;
      pattern     = '0;
      errors      = 0;
      texts       = 0;
      found_count = 0;
      clear_text();
   endfunction

   function void clear_text();
      foreach (window[i]) window[i] = 8'h00;
      seen_count = '0;
      matched    = 1'b0;
      match_pos  = '0;
   endfunction

   // Length in effect: zero acts as one, oversize clamps to the window depth
   function int used_len();
      if (len_reg == 0) return 1;
      if (len_reg > fsub_pkg::MAX_PATTERN_DEF) return fsub_pkg::MAX_PATTERN_DEF;
      return int'(len_reg);
   endfunction

   function void write_reg(logic [fsub_pkg::CSR_IDX_BITS-1:0] idx, logic [63:0] v);
      case (idx)
         fsub_pkg::REG_PATTERN_LENGTH: len_reg = v[4:0];
         fsub_pkg::REG_PATTERN_LOW:    pattern[63:0] = v;
         fsub_pkg::REG_PATTERN_HIGH:   pattern[127:64] = v;
         default: ;
      endcase
   endfunction

   function void note_byte(logic [7:0] b, logic is_last);
      int               eff;
      bit               hit;
      match_result_type res;
      eff = used_len();
      for (int i = 15; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (seen_count != 16'hFFFF) seen_count++;
      // occurrence must lie wholly inside the current text
      hit = (seen_count >= eff);
      for (int k = 0; k < eff; k++)
         if (window[eff-1-k] != pattern[8*k +: 8]) hit = 1'b0;
      if (hit && !matched) begin
         matched   = 1'b1;
         match_pos = seen_count - 16'(eff);
      end
      if (is_last) begin
         res.found = matched;
         res.start = matched ? match_pos : 16'd0;
         expected_q.push_back(res);
         texts++;
         if (matched) found_count++;
         clear_text();
      end
   endfunction

   function void check_result(logic found, logic [15:0] start);
      match_result_type want;
      if (expected_q.size() == 0) begin
         $error("result beat with nothing expected: found %0d match_start %0d", found, start);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (found !== want.found) begin
         $error("found mismatch: expected %0d, actual %0d", want.found, found);
         errors++;
      end
      if (start !== want.start) begin
         $error("match_start mismatch: expected %0d, actual %0d", want.start, start);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module first_substring_match_tb;

   localparam int LIMIT = 100_000;
   localparam int LONG_HOLD = 150;
   localparam logic [fsub_pkg::CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] text_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] match_start
   logic        rsp_tuser;   // [0] found
   logic        csr_we;
   logic [fsub_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [fsub_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   match_scoreboard sb;
   bit calm;          // no idling on either side
   bit hold_pending;  // ask the receiver for one long hold-off
   int bytes_sent;

   first_substring_match DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Monitors: sampled mid-cycle, a beat with valid and ready moves at the next edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // Result side backpressure: short random bursts plus one long hold on request
   initial begin : rsp_side
      int hold_left;
      int burst;
      hold_left  = 0;
      burst      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One text beat, with an occasional gap in front of it
   task automatic send_beat(input logic [7:0] b, input logic is_last);
      int gap;
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      bytes_sent++;
   endtask

   // Random text drawn mostly from the pattern's own bytes; optionally a planted
   // copy, which may run past the end of the text
   task automatic send_text(input int len, input bit plant);
      int         eff;
      int         pos;
      int         sel;
      logic [7:0] txt [$];
      eff = sb.used_len();
      for (int i = 0; i < len; i++) begin
         sel = $urandom_range(0, eff - 1);
         if ($urandom_range(0, 2) != 0) txt.push_back(sb.pattern[8*sel +: 8]);
         else txt.push_back(8'($urandom_range(0, 255)));
      end
      if (plant) begin
         pos = $urandom_range(0, len - 1);
         for (int k = 0; k < eff && pos + k < len; k++) txt[pos+k] = sb.pattern[8*k +: 8];
      end
      foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1);
   endtask

   // Register write; the caller drops csr_we after the last one of a group
   task automatic write_csr(input logic [fsub_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [63:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic close_csr();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Let every expected result drain, then allow settle time
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int           ph;
      int           len_sel;
      int           phase_start;
      logic [63:0]  len_word;
      logic [127:0] pat_word;
      sb           = new();
      calm         = 1'b0;
      hold_pending = 1'b0;
      bytes_sent   = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tlast    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = fsub_pkg::REG_PATTERN_LENGTH;
      csr_wdata    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset pattern is a single zero byte: hit at position 0, then a miss
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      wait_idle();

      // Length zero acts as one; write to an unused index must not land anywhere
      write_csr(fsub_pkg::REG_PATTERN_LENGTH, 64'd0);
      write_csr(fsub_pkg::REG_PATTERN_LOW, 64'hFF);
      write_csr(REG_UNUSED, 64'd2);
      close_csr();
      send_beat(8'h12, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1);
      wait_idle();

      // "abc": text shorter than the pattern, exact text, later hit
      write_csr(fsub_pkg::REG_PATTERN_LENGTH, 64'd3);
      write_csr(fsub_pkg::REG_PATTERN_LOW, 64'h636261);
      close_csr();
      send_beat(8'h61, 1'b0);
      send_beat(8'h62, 1'b1);
      send_beat(8'h61, 1'b0);
      send_beat(8'h62, 1'b0);
      send_beat(8'h63, 1'b1);
      send_beat(8'h63, 1'b0);
      send_beat(8'h61, 1'b0);
      send_beat(8'h62, 1'b0);
      send_beat(8'h63, 1'b1);
      wait_idle();

      // Oversize length clamps to 16; full-window pattern fills the text
      write_csr(fsub_pkg::REG_PATTERN_LENGTH, 64'd20);
      write_csr(fsub_pkg::REG_PATTERN_LOW, '1);
      write_csr(fsub_pkg::REG_PATTERN_HIGH, '0);
      close_csr();
      for (int i = 0; i < 16; i++) send_beat((i < 8) ? 8'hFF : 8'h00, i == 15);
      wait_idle();

      // Random phases, each with its own register setting; the last two run calm
      for (ph = 0; ph < 12; ph++) begin
         calm = (ph >= 10);
         case (ph % 6)
            0:       len_sel = 1;
            1:       len_sel = 16;
            2:       len_sel = 0;
            3:       len_sel = $urandom_range(17, 31);
            default: len_sel = $urandom_range(2, 15);
         endcase
         // upper bits of the length word are don't-care
         len_word      = {$urandom, $urandom};
         len_word[4:0] = 5'(len_sel);
         case (ph % 3)
            0: pat_word = {$urandom, $urandom, $urandom, $urandom};
            1: for (int i = 0; i < 16; i++) pat_word[8*i +: 8] = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62;
            default: pat_word = (ph % 2 == 0) ? '0 : '1;
         endcase
         write_csr(fsub_pkg::REG_PATTERN_LENGTH, len_word);
         write_csr(fsub_pkg::REG_PATTERN_LOW, pat_word[63:0]);
         write_csr(fsub_pkg::REG_PATTERN_HIGH, pat_word[127:64]);
         close_csr();

         // Long receiver hold while short texts keep coming: fills the output stage
         if (ph == 4) begin
            hold_pending = 1'b1;
            for (int i = 0; i < 30; i++) send_text(1, $urandom_range(0, 1));
         end

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 100) begin
            if ($urandom_range(0, 4) == 0) send_text($urandom_range(1, 40), 1'b0);
            else send_text($urandom_range(1, 30), 1'b1);
         end
         wait_idle();
      end

      $display("Covered %0d texts over %0d bytes, %0d with a hit, pattern lengths 0 to 31",
               sb.texts, bytes_sent, sb.found_count);
      $display("including short texts, a long result hold-off and an unused index write");
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
